>>> src/llei_pkg.sv
// Shared types and constants for the link-loss engine immobiliser.
`timescale 1ns / 1ps

package llei_pkg;

	// Field widths
	localparam int OP_W     = 3;
	localparam int RPM_W    = 16;
	localparam int MS_W     = 16;
	localparam int TMO_W    = 8;
	localparam int MODE_W   = 2;
	localparam int REM_W    = 18;
	localparam int SEC_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// Stream payload widths, whole bytes
	localparam int IN_DAT_W  = 40;
	localparam int OUT_DAT_W = 16;

	// Event codes
	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_EN     = 3'd1;
	localparam logic [OP_W-1:0] OP_CONNECT    = 3'd2;
	localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd3;
	localparam logic [OP_W-1:0] OP_ACK        = 3'd4;

	// Reported mode codes
	localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COUNTDOWN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_KILLED    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RPM   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_S = 1'b1;

	localparam logic [RPM_W-1:0] MIN_RPM_RST   = 16'd500;
	localparam logic [TMO_W-1:0] TIMEOUT_S_RST = 8'd30;

	localparam logic [9:0] MS_PER_S = 10'd1000;
	localparam int unsigned REM_MAX = 255 * 1000;

	// floor(x / 1000) = (x * RECIP) >> RECIP_SH, exact for x below 2**18
	localparam int RECIP_SH = 28;
	localparam int RECIP_W  = 19;
	localparam logic [RECIP_W-1:0] RECIP = 19'd268436;
	localparam int PROD_W   = REM_W + RECIP_W;

	typedef struct packed {
		logic [MS_W-1:0]  elapsed_ms;
		logic [RPM_W-1:0] rpm;
		logic             enable_value;
		logic [OP_W-1:0]  op;
	} item_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem_ms;
		logic              link_up;
		logic              is_enabled;
		logic [MODE_W-1:0] mode;
	} stat_t;

	typedef struct packed {
		logic [SEC_W-1:0]  seconds_left;
		logic              link_up;
		logic              is_enabled;
		logic [MODE_W-1:0] mode;
	} res_t;

endpackage

>>> src/link_loss_engine_immobilizer_core.sv
// Top level of the link-loss engine immobiliser.
`timescale 1ns / 1ps

// Link-loss immobiliser: each request on the slave stream is one event (tick
// with rpm and elapsed milliseconds, set enable, link connect, link disconnect
// or unlock acknowledge) and yields exactly one result on the master stream
// with the mode (idle, countdown, killed), the enable and link flags and the
// whole seconds left in a countdown. One request is taken every clock cycle
// unless a master-side stall fills the registers; each result passes three
// registers in order: an input register, the state update (two compares and
// one 18-bit subtraction against the held state) and a result register that
// divides by 1000 through a reciprocal multiply. A stall on the master side
// back-pressures stage by stage, so the input still takes a request while a
// finished result waits.
// Write min_rpm (index 0) and timeout_s (index 1) only while no request is
// in flight; they reset to 500 rpm and 30 s.
module link_loss_engine_immobilizer_core import llei_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// op[2:0], enable_value[3], rpm[19:4], elapsed_ms[35:20], zero fill
	input  logic [IN_DAT_W-1:0]  s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// mode[1:0], is_enabled[2], link_up[3], seconds_left[11:4], zero fill
	output logic [OUT_DAT_W-1:0] m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	logic  vld_s1, vld_s2, vld_s3;
	item_t item_s1;
	logic  adv_s3, adv_s2, fire;
	stat_t stat;
	res_t  res;

	// stage advances when it is empty or its contents move on
	assign adv_s3        = !vld_s3 || m_axis_tready;
	assign adv_s2        = !vld_s2 || adv_s3;
	assign fire          = vld_s1 && adv_s2;
	assign s_axis_tready = !vld_s1 || adv_s2;

	// input register: hold the request until the state update takes it
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	// valid chain: stage 2 payload is the state itself, held until sampled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	llei_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stat      (stat)
	);

	// sample the state into the result register as stage 2 drains
	llei_sec u_sec (
		.clk  (clk),
		.load (vld_s2 && adv_s3),
		.stat (stat),
		.res  (res)
	);

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = {{(OUT_DAT_W-$bits(res_t)){1'b0}}, res};

	// every applied event leaves a pending result in stage 2
	a_event_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> vld_s2)
		else $error("applied event has no pending result");

	// seconds are reported only during a countdown
	a_secs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (res.mode != MODE_COUNTDOWN)) |-> (res.seconds_left == '0))
		else $error("seconds reported outside countdown");

	// a stalled result is not overwritten
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(res))
		else $error("stalled result changed");

endmodule

>>> src/llei_fsm.sv
// Immobiliser state machine and configuration registers.
`timescale 1ns / 1ps

module llei_fsm import llei_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  item_t                item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	output stat_t                stat
);

	typedef enum logic [MODE_W-1:0] {
		ST_IDLE      = MODE_IDLE,
		ST_COUNTDOWN = MODE_COUNTDOWN,
		ST_KILLED    = MODE_KILLED
	} state_t;

	state_t             st_q, st_d;
	logic               en_q, en_d;
	logic               link_q, link_d;
	logic [REM_W-1:0]   rem_q, rem_d;
	logic [RPM_W-1:0]   min_rpm_q;
	logic [TMO_W-1:0]   timeout_s_q;
	logic               running;
	logic [REM_W-1:0]   load_ms;
	logic [REM_W-1:0]   dt;

	assign running = item.rpm >= min_rpm_q;
	assign load_ms = {{(REM_W-TMO_W){1'b0}}, timeout_s_q}
		* {{(REM_W-10){1'b0}}, MS_PER_S};
	assign dt      = {{(REM_W-MS_W){1'b0}}, item.elapsed_ms};

	always_comb begin
		st_d   = st_q;
		en_d   = en_q;
		link_d = link_q;
		rem_d  = rem_q;
		unique case (item.op)
			OP_TICK: begin
				if (en_q) begin
					if (st_q == ST_IDLE) begin
						if (!link_q && running) begin
							st_d  = ST_COUNTDOWN;
							rem_d = load_ms;
						end
					end else if (st_q == ST_COUNTDOWN) begin
						if (link_q) begin
							st_d = ST_IDLE;
						end else if (rem_q > dt) begin
							rem_d = rem_q - dt;
						end else begin
							rem_d = '0;
							st_d  = ST_KILLED;
						end
					end
				end
			end
			OP_SET_EN: begin
				en_d = item.enable_value;
				if (!item.enable_value && st_q == ST_COUNTDOWN) begin
					st_d = ST_IDLE;
				end
			end
			OP_CONNECT: begin
				link_d = 1'b1;
				if (st_q == ST_COUNTDOWN) begin
					st_d = ST_IDLE;
				end
			end
			OP_DISCONNECT: begin
				link_d = 1'b0;
			end
			OP_ACK: begin
				if (st_q == ST_KILLED && link_q) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			en_q   <= 1'b0;
			link_q <= 1'b0;
			rem_q  <= '0;
		end else if (fire) begin
			st_q   <= st_d;
			en_q   <= en_d;
			link_q <= link_d;
			rem_q  <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rpm_q   <= MIN_RPM_RST;
			timeout_s_q <= TIMEOUT_S_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MIN_RPM) begin
				min_rpm_q <= cfg_wdata;
			end else if (cfg_index == CFG_TIMEOUT_S) begin
				timeout_s_q <= cfg_wdata[TMO_W-1:0];
			end
		end
	end

	assign stat.mode       = st_q;
	assign stat.is_enabled = en_q;
	assign stat.link_up    = link_q;
	assign stat.rem_ms     = rem_q;

	// state moves only when an event is applied
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> ($stable(st_q) && $stable(rem_q) && $stable(en_q) && $stable(link_q)))
		else $error("immobiliser state changed without an event");

	// countdown never holds more than the longest timeout
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COUNTDOWN) |-> (rem_q <= REM_W'(REM_MAX)))
		else $error("countdown exceeds the longest timeout");

endmodule

>>> src/llei_sec.sv
// Result register: converts the remaining milliseconds to whole seconds.
`timescale 1ns / 1ps

module llei_sec import llei_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  stat_t stat,
	output res_t  res
);

	logic [PROD_W-1:0] prod;
	res_t              res_s3;

	assign prod = {{(PROD_W-REM_W){1'b0}}, stat.rem_ms}
		* {{(PROD_W-RECIP_W){1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (load) begin
			res_s3.mode       <= stat.mode;
			res_s3.is_enabled <= stat.is_enabled;
			res_s3.link_up    <= stat.link_up;
			res_s3.seconds_left <= (stat.mode == MODE_COUNTDOWN)
				? prod[RECIP_SH +: SEC_W] : '0;
		end
	end

	assign res = res_s3;

endmodule

>>> test/link_loss_engine_immobilizer_core_tb.sv
// Self-checking testbench for the link-loss engine immobiliser core.
`timescale 1ns / 1ps

module link_loss_engine_immobilizer_core_tb;
	import llei_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 165;
	localparam int TAIL_CYCLES = 8;

	// Mirrors the immobiliser state from accepted requests and checks each status word.
	class immob_scoreboard;
		logic [RPM_W-1:0]  min_rpm;
		logic [TMO_W-1:0]  timeout_s;
		logic [MODE_W-1:0] imm_mode;
		logic              enabled;
		logic              linked;
		logic [REM_W-1:0]  remain_ms;
		res_t              expected_status[$];
		int errors, reports, n_requests, n_results, n_loads, n_kills, n_unlocks;

		function new();
			min_rpm    = MIN_RPM_RST;
			timeout_s  = TIMEOUT_S_RST;
			imm_mode   = MODE_IDLE;
			enabled    = 1'b0;
			linked     = 1'b0;
			remain_ms  = '0;
			errors     = 0;
			reports    = 0;
			n_requests = 0;
			n_results  = 0;
			n_loads    = 0;
			n_kills    = 0;
			n_unlocks  = 0;
		endfunction

		function void report_failure(string msg);
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
		endfunction

		// Advance the state by one accepted request and queue the status it yields.
		function void note_request(item_t it);
			res_t want;
			n_requests++;
			case (it.op)
				OP_TICK: begin
					if (enabled && imm_mode == MODE_IDLE) begin
						if (!linked && it.rpm >= min_rpm) begin
							imm_mode  = MODE_COUNTDOWN;
							remain_ms = REM_W'(int'(timeout_s) * int'(MS_PER_S));
							n_loads++;
						end
					end else if (enabled && imm_mode == MODE_COUNTDOWN) begin
						if (linked)
							imm_mode = MODE_IDLE;
						else if (remain_ms > REM_W'(it.elapsed_ms))
							remain_ms = remain_ms - REM_W'(it.elapsed_ms);
						else begin
							remain_ms = '0;
							imm_mode  = MODE_KILLED;
							n_kills++;
						end
					end
				end
				OP_SET_EN: begin
					enabled = it.enable_value;
					if (!enabled && imm_mode == MODE_COUNTDOWN)
						imm_mode = MODE_IDLE;
				end
				OP_CONNECT: begin
					linked = 1'b1;
					if (imm_mode == MODE_COUNTDOWN)
						imm_mode = MODE_IDLE;
				end
				OP_DISCONNECT: begin
					linked = 1'b0;
				end
				OP_ACK: begin
					if (imm_mode == MODE_KILLED && linked) begin
						imm_mode = MODE_IDLE;
						n_unlocks++;
					end
				end
				default: begin
				end
			endcase
			want.mode         = imm_mode;
			want.is_enabled   = enabled;
			want.link_up      = linked;
			want.seconds_left = (imm_mode == MODE_COUNTDOWN) ?
				SEC_W'(remain_ms / REM_W'(MS_PER_S)) : '0;
			expected_status.push_back(want);
		endfunction

		function void check_result(res_t got);
			res_t want;
			n_results++;
			if (expected_status.size() == 0) begin
				report_failure($sformatf("status word %h with nothing outstanding", got));
				return;
			end
			want = expected_status.pop_front();
			if (got.mode !== want.mode || got.is_enabled !== want.is_enabled ||
			    got.link_up !== want.link_up || got.seconds_left !== want.seconds_left)
				report_failure($sformatf(
					"status %0d exp mode %0d en %b link %b secs %0d, got mode %0d en %b link %b secs %0d",
					n_results, want.mode, want.is_enabled, want.link_up, want.seconds_left,
					got.mode, got.is_enabled, got.link_up, got.seconds_left));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_DAT_W-1:0]  s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_DAT_W-1:0] m_axis_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	immob_scoreboard sb;
	int src_idle_pct;
	int sink_idle_pct;
	int n_sent;
	bit hold_request;

	link_loss_engine_immobilizer_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Offer one request, idling first at the sender's current rate, and hold it
	// until the block takes it. The scoreboard sees it at the accepting edge.
	task automatic send_event(input logic [OP_W-1:0] op, input logic en,
	                          input logic [RPM_W-1:0] rpm, input logic [MS_W-1:0] ms);
		item_t it;
		it.op           = op;
		it.enable_value = en;
		it.rpm          = rpm;
		it.elapsed_ms   = ms;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DAT_W - $bits(item_t)){1'b0}}, it};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_request(it);
		n_sent++;
	endtask

	// Drop the request line and wait until every status word has come back.
	task automatic drain_requests();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_status.size() != 0)
			@(posedge clk);
	endtask

	// Write both limits on back-to-back edges while the block is empty.
	task automatic program_limits(input logic [RPM_W-1:0] rpm_thr,
	                              input logic [TMO_W-1:0] secs);
		drain_requests();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_RPM;
		cfg_wdata <= CFG_DAT_W'(rpm_thr);
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT_S;
		cfg_wdata <= CFG_DAT_W'(secs);
		@(posedge clk);
		cfg_we       <= 1'b0;
		sb.min_rpm   = rpm_thr;
		sb.timeout_s = secs;
	endtask

	// Any event with random content, including the unused codes; a good share
	// of the speeds sit on or just under the running threshold.
	task automatic send_noise();
		int pick;
		logic [OP_W-1:0]  op;
		logic [RPM_W-1:0] rpm;
		pick = $urandom_range(99);
		if (pick < 40)
			op = OP_TICK;
		else if (pick < 55)
			op = OP_SET_EN;
		else if (pick < 70)
			op = OP_CONNECT;
		else if (pick < 85)
			op = OP_DISCONNECT;
		else if (pick < 95)
			op = OP_ACK;
		else
			op = OP_ACK + OP_W'($urandom_range(1, 3));
		rpm = RPM_W'($urandom);
		if ($urandom_range(2) == 0)
			rpm = sb.min_rpm - RPM_W'($urandom_range(1));
		send_event(op, 1'($urandom), rpm, MS_W'($urandom));
	endtask

	// A full lock-out: arm, lose the link with the engine running, count down
	// in a few ticks that may or may not use up the time, then mostly
	// reconnect and acknowledge. Occasional noise breaks the sequence.
	task automatic run_lockout_sequence();
		int ticks;
		int span;
		int cap;
		ticks = $urandom_range(1, 8);
		span  = (int'(sb.timeout_s) * int'(MS_PER_S)) / ticks;
		cap   = (2 * span + 1 > 65535) ? 65535 : 2 * span + 1;
		send_event(OP_SET_EN, 1'b1, RPM_W'($urandom), MS_W'($urandom));
		send_event(OP_DISCONNECT, 1'($urandom), RPM_W'($urandom), MS_W'($urandom));
		send_event(OP_TICK, 1'($urandom), RPM_W'($urandom_range(65535, sb.min_rpm)),
			MS_W'($urandom));
		for (int i = 0; i <= ticks; i++) begin
			if ($urandom_range(9) == 0)
				send_noise();
			send_event(OP_TICK, 1'($urandom), RPM_W'($urandom), MS_W'($urandom_range(cap)));
		end
		if ($urandom_range(3) != 0) begin
			send_event(OP_CONNECT, 1'($urandom), RPM_W'($urandom), MS_W'($urandom));
			send_event(OP_ACK, 1'($urandom), RPM_W'($urandom), MS_W'($urandom));
		end
	endtask

	// Status side: check every accepted word, then pick next cycle's ready.
	// A long hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(res_t'(m_axis_tdata[$bits(res_t)-1:0]));
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Hard stop in case the handshake locks up.
	initial begin
		#(20_000_000);
		$display("Timeout: status words still outstanding or input stalled");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		sb            = new();
		src_idle_pct  = 23;
		sink_idle_pct = 70;
		n_sent        = 0;
		hold_request  = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_MIN_RPM;
		cfg_wdata     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset limits (500 rpm, 30 s).
		// Disabled: a running tick is ignored, so is an acknowledge in idle.
		send_event(OP_TICK, 1'b1, 16'hFFFF, 16'hFFFF);
		send_event(OP_ACK, 1'b1, 16'h0000, 16'h0000);
		// Unused codes only report the state.
		send_event(OP_ACK + OP_W'(1), 1'b1, 16'hFFFF, 16'hFFFF);
		send_event(OP_ACK + OP_W'(3), 1'b0, 16'h0000, 16'h0000);
		send_event(OP_SET_EN, 1'b1, 16'h0000, 16'h0000);
		// Just under the threshold does not count as running.
		send_event(OP_TICK, 1'b0, MIN_RPM_RST - 16'd1, 16'd0);
		// Loading tick subtracts nothing, even with the largest elapsed time.
		send_event(OP_TICK, 1'b0, MIN_RPM_RST, 16'hFFFF);
		send_event(OP_TICK, 1'b0, 16'd0, 16'd999);
		// Disabling cancels the countdown.
		send_event(OP_SET_EN, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_SET_EN, 1'b1, 16'h0000, 16'h0000);
		send_event(OP_TICK, 1'b0, 16'hFFFF, 16'd5);
		// Reconnecting cancels it as well.
		send_event(OP_CONNECT, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_DISCONNECT, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_TICK, 1'b0, 16'd1000, 16'd0);
		// One millisecond left shows as zero seconds; an exact hit kills.
		send_event(OP_TICK, 1'b0, 16'd0, 16'd29999);
		send_event(OP_TICK, 1'b0, 16'd0, 16'd1);
		// Killed: acknowledge with the link down and further ticks change nothing.
		send_event(OP_ACK, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_TICK, 1'b0, 16'hFFFF, 16'hFFFF);
		send_event(OP_CONNECT, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_ACK, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_DISCONNECT, 1'b0, 16'h0000, 16'h0000);

		// Zero timeout: loads nothing and the next countdown tick kills.
		program_limits(MIN_RPM_RST, 8'd0);
		send_event(OP_TICK, 1'b0, MIN_RPM_RST, 16'd0);
		send_event(OP_TICK, 1'b0, 16'd0, 16'd0);
		send_event(OP_CONNECT, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_ACK, 1'b0, 16'h0000, 16'h0000);
		send_event(OP_DISCONNECT, 1'b0, 16'h0000, 16'h0000);

		// Longest timeout: 255 s, then the largest single step.
		program_limits(MIN_RPM_RST, 8'hFF);
		send_event(OP_TICK, 1'b0, MIN_RPM_RST, 16'd0);
		send_event(OP_TICK, 1'b0, 16'd0, 16'hFFFF);

		// Random part: six limit settings, two per idle pattern.
		for (int phase = 0; phase < 6; phase++) begin
			int target;
			case (phase)
				0: program_limits(MIN_RPM_RST, 8'd1);
				1: program_limits(16'hFFFF, 8'hFF);
				2: program_limits(16'd0, TMO_W'($urandom_range(1, 255)));
				3: program_limits(RPM_W'($urandom), TIMEOUT_S_RST);
				4: program_limits(RPM_W'($urandom), TMO_W'($urandom_range(1, 255)));
				default: program_limits(16'd1, 8'd2);
			endcase
			if (phase < 2) begin
				src_idle_pct  = 23;
				sink_idle_pct = 70;
			end else if (phase < 4) begin
				src_idle_pct  = 70;
				sink_idle_pct = 23;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			// Stall the status side for a long stretch so the pipe backs up.
			if (phase == 1 || phase == 4)
				hold_request = 1'b1;
			target = n_sent + PHASE_ITEMS;
			while (n_sent < target) begin
				if ($urandom_range(99) < 60)
					run_lockout_sequence();
				else
					send_noise();
			end
		end

		drain_requests();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d events across nine limit settings and three idle patterns;",
			sb.n_requests);
		$display("checked %0d status words: %0d countdowns, %0d fuel cuts, %0d unlocks, %0d errors",
			sb.n_results, sb.n_loads, sb.n_kills, sb.n_unlocks, sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
